[rtl/mec_pkg.sv]
// Shared constants and types for the escape-time checksum block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mec_pkg;

  localparam int unsigned DIM_W   = 11;
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned ITER_W  = 10;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned QUOT_W  = 20;
  localparam int unsigned DVD_W   = 30;
  localparam int unsigned Z_W     = 24;
  localparam int unsigned MUL_W   = 28;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned SQ_W    = 48;
  localparam int unsigned DIVA_W  = 37;

  localparam logic [DIM_W-1:0]  MAX_DIM   = 11'd1024;
  localparam logic [DVD_W-1:0]  FX_SCALE  = 30'd1000000;
  localparam logic signed [Z_W-1:0] CR_OFFSET = 24'sd2500000;
  localparam logic signed [Z_W-1:0] CI_OFFSET = 24'sd1000000;
  localparam logic [SQ_W:0]     MAG_LIMIT = 49'd4000000000000;
  // floor(2^40 / 15625): scaled reciprocal of the odd part of the scale
  localparam logic [26:0]       RECIP_LO  = 27'd70368744;
  localparam logic [15:0]       DIV_LO    = 16'd15625;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ITER_LIMIT   = 2'd2
  } cfg_index_e;

endpackage
`default_nettype wire

[rtl/mec_coord_div.sv]
// Restoring divider for pixel-to-coordinate mapping: (num * scale) / den.
// Depends on mec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mec_coord_div
  import mec_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PIX_W-1:0]  num_i,
  input  wire logic [DIM_W-1:0]  den_i,
  output logic                   done_o,
  output logic [QUOT_W-1:0]      quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic [DIM_W-1:0]  rem_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DIM_W-1:0]  den_q;
  logic [DIM_W:0]    trial;
  logic              fits;
  logic [DIM_W:0]    trial_sub;

  assign trial     = {rem_q, dvd_q[DVD_W-1]};
  assign fits      = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= DVD_W'(num_i) * FX_SCALE;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[DIM_W-1:0] : trial[DIM_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[QUOT_W-1:0];

endmodule
`default_nettype wire

[rtl/mec_mult.sv]
// Shared signed multiplier with a registered product.
// Depends on mec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mec_mult
  import mec_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [MUL_W-1:0]  a_i,
  input  wire logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0]      p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

[rtl/mec_escape_seq.sv]
// Escape-time iteration sequencer around one shared multiplier; divides by
// the fixed-point scale with a reciprocal product and one correction.
// Depends on mec_pkg and mec_mult.
`timescale 1ns / 1ps
`default_nettype none
module mec_escape_seq
  import mec_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [Z_W-1:0]  cr_i,
  input  wire logic signed [Z_W-1:0]  ci_i,
  input  wire logic [ITER_W-1:0]      limit_i,
  output logic                        done_o,
  output logic [ITER_W-1:0]           count_o
);

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_SQR, SQ_SQI, SQ_CHK, SQ_CRS, SQ_RCP, SQ_BAK, SQ_FIX
  } seq_state_e;

  seq_state_e                state_q;
  logic signed [Z_W-1:0]     zr_q, zi_q, zr_nx_q;
  logic [SQ_W-1:0]           sqr_q;
  logic [SQ_W-1:0]           cross_q;
  logic [DIVA_W-1:0]         div_a_q;
  logic                      div_neg_q;
  logic                      div_sel_q;
  logic [Z_W-1:0]            qest_q;
  logic [ITER_W-1:0]         n_q;
  logic                      done_q;

  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic [SQ_W:0]             mag;
  logic [SQ_W:0]             diff;
  logic [SQ_W:0]             diff_abs;
  logic [SQ_W-1:0]           cross_abs;
  logic                      stop;
  logic [15:0]               rem_lo;
  logic [Z_W-1:0]            qfix;
  logic signed [Z_W-1:0]     cbase;
  logic [Z_W:0]              res_w;
  logic signed [Z_W-1:0]     zres;

  mec_mult u_mult (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      SQ_SQR: begin
        op_a = {{(MUL_W-Z_W){zr_q[Z_W-1]}}, zr_q};
        op_b = {{(MUL_W-Z_W){zr_q[Z_W-1]}}, zr_q};
      end
      SQ_SQI: begin
        op_a = {{(MUL_W-Z_W){zi_q[Z_W-1]}}, zi_q};
        op_b = {{(MUL_W-Z_W){zi_q[Z_W-1]}}, zi_q};
      end
      SQ_CRS: begin
        op_a = {{(MUL_W-Z_W){zr_q[Z_W-1]}}, zr_q};
        op_b = {{(MUL_W-Z_W){zi_q[Z_W-1]}}, zi_q};
      end
      SQ_RCP: begin
        op_a = {1'b0, div_a_q[DIVA_W-1:10]};
        op_b = {1'b0, RECIP_LO};
      end
      SQ_BAK: begin
        op_a = {{(MUL_W-Z_W){1'b0}}, prod[53:30]};
        op_b = {{(MUL_W-16){1'b0}}, DIV_LO};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mag       = {1'b0, sqr_q} + {1'b0, prod[SQ_W-1:0]};
  assign diff      = {1'b0, sqr_q} - {1'b0, prod[SQ_W-1:0]};
  assign diff_abs  = diff[SQ_W] ? (~diff + 49'd1) : diff;
  assign cross_abs = cross_q[SQ_W-1] ? (~cross_q + 48'd1) : cross_q;
  assign stop      = (n_q >= limit_i) || (mag > MAG_LIMIT);

  assign rem_lo = div_a_q[15:0] - prod[15:0];
  assign qfix   = qest_q + Z_W'(rem_lo >= DIV_LO);
  assign cbase  = div_sel_q ? ci_i : cr_i;
  assign res_w  = div_neg_q ? ({cbase[Z_W-1], cbase} - {1'b0, qfix})
                            : ({cbase[Z_W-1], cbase} + {1'b0, qfix});
  assign zres   = res_w[Z_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            zr_q    <= '0;
            zi_q    <= '0;
            n_q     <= '0;
            state_q <= SQ_SQR;
          end
        end
        SQ_SQR: state_q <= SQ_SQI;
        SQ_SQI: begin
          sqr_q   <= prod[SQ_W-1:0];
          state_q <= SQ_CHK;
        end
        SQ_CHK: begin
          if (stop) begin
            done_q  <= 1'b1;
            state_q <= SQ_IDLE;
          end else begin
            div_a_q   <= diff_abs[42:6];
            div_neg_q <= diff[SQ_W];
            div_sel_q <= 1'b0;
            state_q   <= SQ_CRS;
          end
        end
        SQ_CRS: state_q <= SQ_RCP;
        SQ_RCP: begin
          if (!div_sel_q) begin
            cross_q <= prod[SQ_W-1:0];
          end
          state_q <= SQ_BAK;
        end
        SQ_BAK: begin
          qest_q  <= prod[53:30];
          state_q <= SQ_FIX;
        end
        SQ_FIX: begin
          if (!div_sel_q) begin
            zr_nx_q   <= zres;
            div_a_q   <= cross_abs[41:5];
            div_neg_q <= cross_q[SQ_W-1];
            div_sel_q <= 1'b1;
            state_q   <= SQ_RCP;
          end else begin
            zi_q    <= zres;
            zr_q    <= zr_nx_q;
            n_q     <= n_q + 10'd1;
            state_q <= SQ_SQR;
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign count_o = n_q;

endmodule
`default_nettype wire

[rtl/mandelbrot_escape_checksum_top.sv]
// Top level: configuration registers, pixel request handshake, coordinate
// mapping and saturating checksum. Depends on mec_pkg, mec_coord_div, mec_escape_seq.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, pixel_x/y, start   | request in
//   out     | out_valid_o/out_ready_i, count, sum, err  | result out
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i         | register write
//
// An in-frame pixel passes through two 30-step restoring divides that map the
// coordinate, then each escape iteration runs on the shared multiplier.
// An out-of-frame pixel skips the divides and the iteration.
// One request is in flight at a time; the result holds until taken.
// Reset restores the register defaults and clears the checksum.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_checksum_top
  import mec_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [PIX_W-1:0]   pixel_x_i,
  input  wire logic [PIX_W-1:0]   pixel_y_i,
  input  wire logic               frame_start_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ITER_W-1:0]       escape_count_o,
  output logic [SUM_W-1:0]        running_sum_o,
  output logic                    coord_error_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [DIM_W-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIVX, ST_DIVY, ST_ITER, ST_OUT
  } top_state_e;

  top_state_e              state_q;
  logic [DIM_W-1:0]        width_q, height_q;
  logic [ITER_W-1:0]       limit_q;
  logic [SUM_W-1:0]        sum_q;
  logic [PIX_W-1:0]        py_q;
  logic [ITER_W-1:0]       count_q;
  logic                    err_q;
  logic signed [Z_W-1:0]   cr_q, ci_q;

  logic                    accept;
  logic                    pix_err;
  logic                    div_start;
  logic                    div_done;
  logic [QUOT_W-1:0]       quot;
  logic [PIX_W-1:0]        div_num;
  logic [DIM_W-1:0]        div_den;
  logic                    seq_start;
  logic                    seq_done;
  logic [ITER_W-1:0]       seq_count;
  logic [DIM_W-1:0]        cfg_dim;
  logic [22:0]             q7;
  logic signed [Z_W-1:0]   cr_d, ci_d;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        sum_base;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign pix_err     = ({1'b0, pixel_x_i} >= width_q) || ({1'b0, pixel_y_i} >= height_q);
  assign div_start   = (accept && !pix_err) || ((state_q == ST_DIVX) && div_done);
  assign div_num     = (state_q == ST_IDLE) ? pixel_x_i : py_q;
  assign div_den     = (state_q == ST_IDLE) ? width_q : height_q;
  assign seq_start   = (state_q == ST_DIVY) && div_done;
  assign cfg_dim     = (cfg_data_i > MAX_DIM) ? MAX_DIM : cfg_data_i;
  assign sum_base    = frame_start_i ? '0 : sum_q;

  assign q7   = ({3'b0, quot} << 3) - {3'b0, quot};
  assign cr_d = $signed({2'b0, q7[22:1]}) - CR_OFFSET;
  assign ci_d = $signed({3'b0, quot, 1'b0}) - CI_OFFSET;

  assign sum_add = {1'b0, sum_q} + {{(SUM_W+1-ITER_W){1'b0}}, seq_count};

  mec_coord_div u_coord_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  mec_escape_seq u_escape_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seq_start),
    .cr_i    (cr_q),
    .ci_i    (ci_q),
    .limit_i (limit_q),
    .done_o  (seq_done),
    .count_o (seq_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd256;
      height_q <= 11'd256;
      limit_q  <= 10'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_dim;
        CFG_FRAME_HEIGHT: height_q <= cfg_dim;
        CFG_ITER_LIMIT:   limit_q  <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      err_q   <= 1'b0;
      count_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sum_q <= sum_base;
            py_q  <= pixel_y_i;
            if (pix_err) begin
              err_q   <= 1'b1;
              count_q <= '0;
              state_q <= ST_OUT;
            end else begin
              err_q   <= 1'b0;
              state_q <= ST_DIVX;
            end
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            cr_q    <= cr_d;
            state_q <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            ci_q    <= ci_d;
            state_q <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (seq_done) begin
            count_q <= seq_count;
            sum_q   <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = (state_q == ST_OUT);
  assign escape_count_o = count_q;
  assign running_sum_o  = sum_q;
  assign coord_error_o  = err_q;

endmodule
`default_nettype wire
